### rtl/sdt_pkg.sv
// Shared types and constants for the sparse DNN tile MAC/ReLU block.
package sdt_pkg;

  localparam int TAPS_DEFAULT    = 32;
  localparam int OUTPUTS_DEFAULT = 16;

  localparam int ACT_W  = 16;
  localparam int WGT_W  = 16;
  localparam int PROD_W = ACT_W + WGT_W + 1;
  localparam int ACC_W  = 40;
  localparam int FRAC_DROP = 14;
  localparam int VAL_W  = 16;
  localparam int SUM_W  = ACC_W - FRAC_DROP + 2;

  localparam logic signed [15:0] BIAS_RESET = -16'sd307;
  localparam logic [15:0]        CEIL_RESET = 16'd32768;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_ACT  = 1'b1
  } req_type_t;

  typedef enum logic {
    CFG_BIAS = 1'b0,
    CFG_CEIL = 1'b1
  } cfg_reg_t;

  // Per-beat control carried down the MAC pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } tap_ctl_t;

endpackage

### rtl/sdt_wmem.sv
// Weight store: one row of weights per tap, single-weight writes, registered row read.
module sdt_wmem #(
  parameter int TAPS    = sdt_pkg::TAPS_DEFAULT,
  parameter int OUTPUTS = sdt_pkg::OUTPUTS_DEFAULT
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [$clog2(TAPS)-1:0]                   waddr,
  input  logic [(OUTPUTS > 1 ? $clog2(OUTPUTS) : 1)-1:0] wcol,
  input  logic [sdt_pkg::WGT_W-1:0]                 wdata,
  input  logic                                      re,
  input  logic [$clog2(TAPS)-1:0]                   raddr,
  output logic [OUTPUTS-1:0][sdt_pkg::WGT_W-1:0]    rdata
);

  logic [OUTPUTS-1:0][sdt_pkg::WGT_W-1:0] mem [TAPS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr][wcol] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/sdt_mac.sv
// Parallel multiply stage and per-neuron accumulators; hands finished sums to the output bank.
module sdt_mac #(
  parameter int OUTPUTS = sdt_pkg::OUTPUTS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  sdt_pkg::tap_ctl_t                      in_ctl,
  input  logic [sdt_pkg::ACT_W-1:0]              in_act,
  input  logic [OUTPUTS-1:0][sdt_pkg::WGT_W-1:0] row,
  output logic                                   pend_last,
  output logic                                   cap_valid,
  output logic [OUTPUTS-1:0][sdt_pkg::ACC_W-1:0] cap_sums
);

  localparam int EXT_W = sdt_pkg::ACC_W - sdt_pkg::PROD_W;

  sdt_pkg::tap_ctl_t p1_ctl;
  sdt_pkg::tap_ctl_t p2_ctl;
  logic [sdt_pkg::ACT_W-1:0] p1_act;
  logic signed [sdt_pkg::PROD_W-1:0] prod [OUTPUTS];
  logic [sdt_pkg::ACC_W-1:0] acc [OUTPUTS];
  logic [sdt_pkg::ACC_W-1:0] sum [OUTPUTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_ctl <= '0;
      p2_ctl <= '0;
    end else if (en) begin
      p1_ctl <= in_ctl;
      p2_ctl <= p1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_act <= in_act;
    end
  end

  always_comb begin
    for (int j = 0; j < OUTPUTS; j++) begin
      sum[j] = acc[j] + {{EXT_W{prod[j][sdt_pkg::PROD_W-1]}}, prod[j]};
      cap_sums[j] = sum[j];
    end
  end

  // last tap sitting in front of the accumulators
  assign pend_last = p2_ctl.valid && p2_ctl.last;
  assign cap_valid = en && pend_last;

  for (genvar j = 0; j < OUTPUTS; j++) begin : g_lane
    always_ff @(posedge clk) begin
      if (en) begin
        prod[j] <= $signed({1'b0, p1_act}) * $signed(row[j]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        acc[j] <= '0;
      end else if (en && p2_ctl.valid) begin
        acc[j] <= p2_ctl.last ? '0 : sum[j];
      end
    end
  end

endmodule

### rtl/sdt_out.sv
// Result bank and drain: rounds, biases and clamps one neuron per beat into the output register.
module sdt_out #(
  parameter int OUTPUTS = sdt_pkg::OUTPUTS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cap_valid,
  input  logic [OUTPUTS-1:0][sdt_pkg::ACC_W-1:0] cap_sums,
  input  logic signed [15:0]                     bias,
  input  logic [15:0]                            clamp_ceiling,
  output logic                                   busy,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [23:0]                            m_axis_tdata,
  output logic                                   m_axis_tlast
);

  localparam int OUT_AW = (OUTPUTS > 1) ? $clog2(OUTPUTS) : 1;
  localparam int SUM_W  = sdt_pkg::SUM_W;

  logic [OUTPUTS-1:0][sdt_pkg::ACC_W-1:0] bank;
  logic [OUT_AW-1:0] cnt;
  logic [6:0] cnt_ext;
  logic load;
  logic cnt_end;
  logic [sdt_pkg::ACC_W-1:0] a;
  logic signed [SUM_W-1:0] v;
  logic [sdt_pkg::VAL_W-1:0] val_next;
  logic [3:0] neuron;
  logic [sdt_pkg::VAL_W-1:0] value;

  assign load    = busy && (!m_axis_tvalid || m_axis_tready);
  assign cnt_end = (cnt == OUT_AW'(OUTPUTS - 1));
  assign cnt_ext = 7'(cnt);

  // floor((a + 2^13) / 2^14) + bias, then clamp to 0..ceiling
  always_comb begin
    a = bank[cnt];
    v = $signed({{2{a[sdt_pkg::ACC_W-1]}}, a[sdt_pkg::ACC_W-1:sdt_pkg::FRAC_DROP]})
      + $signed({{(SUM_W-1){1'b0}}, a[sdt_pkg::FRAC_DROP-1]})
      + $signed({{(SUM_W-16){bias[15]}}, bias});
    if (v[SUM_W-1]) begin
      val_next = '0;
    end else if (v > $signed({{(SUM_W-16){1'b0}}, clamp_ceiling})) begin
      val_next = clamp_ceiling;
    end else begin
      val_next = v[sdt_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cap_valid) begin
      bank <= cap_sums;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cap_valid) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (load) begin
        if (cnt_end) begin
          busy <= 1'b0;
          cnt  <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      if (load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neuron       <= cnt_ext[3:0];
      value        <= val_next;
      m_axis_tlast <= cnt_end;
    end
  end

  assign m_axis_tdata = {4'b0, value, neuron};

endmodule

### rtl/sparse_dnn_tile_mac_relu.sv
// Sparse DNN tile: weight store, per-tap multiply-accumulate, bias, clamp and result drain.
// A last-tap beat's first result passes the row, product, bank and output registers;
// the remaining OUTPUTS-1 results follow one per cycle when m_axis_tready stays high.
// Throughput: one input beat per cycle; input stalls only when a last tap reaches
// the accumulators while the previous image's OUTPUTS results still drain from the bank.
// Reset (rst, synchronous): accumulators cleared, pipeline emptied, bias = -307,
// clamp_ceiling = 32768; weight store contents are undefined until written.
module sparse_dnn_tile_mac_relu #(
  parameter int TAPS    = sdt_pkg::TAPS_DEFAULT,
  parameter int OUTPUTS = sdt_pkg::OUTPUTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // tap_index, neuron_index, weight_value, activation, pad
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_neuron, out_value, pad
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int TAP_AW = $clog2(TAPS);
  localparam int OUT_AW = (OUTPUTS > 1) ? $clog2(OUTPUTS) : 1;

  logic [4:0]  tap_index;
  logic [3:0]  neuron_index;
  logic [15:0] weight_value;
  logic [15:0] activation;
  logic [8:0]  tap_ext;
  logic [6:0]  col_ext;
  logic        tap_ok;
  logic        col_ok;
  logic        accept;
  logic        adv;
  logic        busy;
  logic        cap_valid;
  logic        cap_valid_pending;
  logic signed [15:0] bias;
  logic [15:0] clamp_ceiling;
  sdt_pkg::req_type_t req_type;
  sdt_pkg::tap_ctl_t  in_ctl;
  logic [OUTPUTS-1:0][sdt_pkg::WGT_W-1:0] row;
  logic [OUTPUTS-1:0][sdt_pkg::ACC_W-1:0] cap_sums;
  logic [6:0] pad_unused;

  assign tap_index    = s_axis_tdata[4:0];
  assign neuron_index = s_axis_tdata[8:5];
  assign weight_value = s_axis_tdata[24:9];
  assign activation   = s_axis_tdata[40:25];
  assign pad_unused   = s_axis_tdata[47:41];
  assign req_type     = sdt_pkg::req_type_t'(s_axis_tuser);

  assign tap_ext = 9'(tap_index);
  assign col_ext = 7'(neuron_index);
  assign tap_ok  = tap_ext < 9'(TAPS);
  assign col_ok  = col_ext < 7'(OUTPUTS);

  // hold the pipeline while a last tap waits for the result bank
  assign adv           = !(busy && cap_valid_pending);
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_ctl.valid = accept && (req_type == sdt_pkg::REQ_ACT) && tap_ok;
    in_ctl.last  = tap_ext == 9'(TAPS - 1);
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias          <= sdt_pkg::BIAS_RESET;
      clamp_ceiling <= sdt_pkg::CEIL_RESET;
    end else if (cfg_valid) begin
      case (sdt_pkg::cfg_reg_t'(cfg_index))
        sdt_pkg::CFG_BIAS: bias <= cfg_data;
        sdt_pkg::CFG_CEIL: clamp_ceiling <= cfg_data;
        default: ;
      endcase
    end
  end

  sdt_wmem #(
    .TAPS    (TAPS),
    .OUTPUTS (OUTPUTS)
  ) u_wmem (
    .clk   (clk),
    .we    (accept && (req_type == sdt_pkg::REQ_LOAD) && tap_ok && col_ok),
    .waddr (tap_ext[TAP_AW-1:0]),
    .wcol  (col_ext[OUT_AW-1:0]),
    .wdata (weight_value),
    .re    (adv),
    .raddr (tap_ext[TAP_AW-1:0]),
    .rdata (row)
  );

  sdt_mac #(
    .OUTPUTS (OUTPUTS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_ctl    (in_ctl),
    .in_act    (activation),
    .row       (row),
    .pend_last (cap_valid_pending),
    .cap_valid (cap_valid),
    .cap_sums  (cap_sums)
  );

  sdt_out #(
    .OUTPUTS (OUTPUTS)
  ) u_out (
    .clk           (clk),
    .rst           (rst),
    .cap_valid     (cap_valid),
    .cap_sums      (cap_sums),
    .bias          (bias),
    .clamp_ceiling (clamp_ceiling),
    .busy          (busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  logic unused_pad;
  assign unused_pad = ^pad_unused;

endmodule

### bench/sparse_dnn_tile_mac_relu_tb.sv
`timescale 1ns / 1ps
// Testbench for sparse_dnn_tile_mac_relu: directed and random tap streams checked per beat.
module sparse_dnn_tile_mac_relu_tb;

  localparam int NTAPS       = sdt_pkg::TAPS_DEFAULT;
  localparam int NOUT        = sdt_pkg::OUTPUTS_DEFAULT;
  localparam int SETTLE      = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 56;
  localparam int NPHASES     = 8;

  typedef struct {
    sdt_pkg::req_type_t kind;
    logic [4:0]  tap;
    logic [3:0]  col;
    logic [15:0] wgt;
    logic [15:0] act;
  } tile_req_t;

  typedef struct {
    logic [3:0]  neuron;
    logic [15:0] value;
    logic        last;
  } neuron_out_t;

  class layer_scoreboard;
    logic [sdt_pkg::WGT_W-1:0] weights [NTAPS][NOUT];
    logic [sdt_pkg::ACC_W-1:0] acc [NOUT];
    logic signed [15:0] bias;
    logic [15:0]        ceiling;
    neuron_out_t        pending_outputs [$];
    int                 errors;

    function new();
      foreach (acc[j]) acc[j] = '0;
      bias    = sdt_pkg::BIAS_RESET;
      ceiling = sdt_pkg::CEIL_RESET;
      errors  = 0;
    endfunction

    function void write_reg(sdt_pkg::cfg_reg_t idx, logic [15:0] data);
      if (idx == sdt_pkg::CFG_BIAS) bias = data;
      else ceiling = data;
    endfunction

    function void note_request(tile_req_t r);
      longint      prod;
      longint      v;
      neuron_out_t e;
      if (r.kind == sdt_pkg::REQ_LOAD) begin
        weights[r.tap][r.col] = r.wgt;
        return;
      end
      for (int j = 0; j < NOUT; j++) begin
        prod   = longint'(r.act) * longint'(signed'(weights[r.tap][j]));
        acc[j] = acc[j] + prod[sdt_pkg::ACC_W-1:0];
      end
      if (r.tap != NTAPS - 1) return;
      for (int j = 0; j < NOUT; j++) begin
        // round half up to Q6.10, then bias and clamp
        v = (longint'(signed'(acc[j])) + 64'sd8192) >>> sdt_pkg::FRAC_DROP;
        v = v + bias;
        if (v < 0) v = 0;
        else if (v > longint'(ceiling)) v = longint'(ceiling);
        e.neuron = 4'(j);
        e.value  = v[15:0];
        e.last   = (j == NOUT - 1);
        pending_outputs.push_back(e);
        acc[j] = '0;
      end
    endfunction

    function void check_output(logic [3:0] neuron, logic [15:0] value, logic last);
      neuron_out_t e;
      if (pending_outputs.size() == 0) begin
        $error("unexpected beat: out_neuron %0d out_value %0d last %0b", neuron, value, last);
        errors++;
        return;
      end
      e = pending_outputs.pop_front();
      if (neuron !== e.neuron) begin
        $error("out_neuron: expected %0d, got %0d", e.neuron, neuron);
        errors++;
      end
      if (value !== e.value) begin
        $error("out_value: expected %0d, got %0d", e.value, value);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0b, got %0b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;   // tap_index, neuron_index, weight_value, activation, pad
  logic        s_axis_tuser  = 1'b0; // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // out_neuron, out_value, pad
  logic        m_axis_tlast;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  sdt_pkg::cfg_reg_t cfg_index = sdt_pkg::CFG_BIAS;
  logic [15:0] cfg_data      = '0;

  layer_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int items_sent     = 0;
  int cycle_count    = 0;

  logic [15:0] bias_tbl [NPHASES] = '{16'hFECD, 16'h0000, 16'h8000, 16'h7FFF,
                                      16'h0000, 16'h0400, 16'hF800, 16'h0000};
  logic [15:0] ceil_tbl [NPHASES] = '{16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                      16'h0000, 16'h0800, 16'h1000, 16'h0000};

  sparse_dnn_tile_mac_relu dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result sink: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_output(m_axis_tdata[3:0], m_axis_tdata[19:4], m_axis_tlast);
  end

  function automatic logic [15:0] rand_weight();
    if ($urandom_range(7) == 0) return 16'($urandom);
    return 16'($urandom_range(4095)) - 16'd2048;
  endfunction

  task automatic send_beat(tile_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.kind;
    s_axis_tdata  <= {7'd0, r.act, r.wgt, r.col, r.tap};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(r);
    items_sent++;
  endtask

  task automatic send_load(logic [4:0] tap, logic [3:0] col, logic [15:0] wgt);
    tile_req_t r;
    r.kind = sdt_pkg::REQ_LOAD;
    r.tap  = tap;
    r.col  = col;
    r.wgt  = wgt;
    r.act  = 16'($urandom);
    send_beat(r);
  endtask

  task automatic send_act(logic [4:0] tap, logic [15:0] act);
    tile_req_t r;
    r.kind = sdt_pkg::REQ_ACT;
    r.tap  = tap;
    r.col  = 4'($urandom);
    r.wgt  = 16'($urandom);
    r.act  = act;
    send_beat(r);
  endtask

  // one image: dense or sparse taps in order, closed by the last tap
  task automatic send_image();
    logic [15:0] mask;
    bit          sparse;
    case ($urandom_range(2))
      0:       mask = 16'hFFFF;
      1:       mask = 16'h0FFF;
      default: mask = 16'h03FF;
    endcase
    sparse = $urandom_range(1);
    for (int k = 0; k < NTAPS - 1; k++)
      if (!sparse || $urandom_range(2) == 0) send_act(5'(k), 16'($urandom) & mask);
    send_act(5'(NTAPS - 1), 16'($urandom) & mask);
  endtask

  task automatic send_weights();
    repeat ($urandom_range(1, 8)) send_load(5'($urandom), 4'($urandom), rand_weight());
  endtask

  // stray taps in any order, repeats allowed
  task automatic send_noise();
    repeat ($urandom_range(1, 4)) send_act(5'($urandom), 16'($urandom));
  endtask

  task automatic set_config(logic [15:0] bias_val, logic [15:0] ceil_val);
    cfg_valid <= 1'b1;
    cfg_index <= sdt_pkg::CFG_BIAS;
    cfg_data  <= bias_val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(sdt_pkg::CFG_BIAS, bias_val);
    cfg_index <= sdt_pkg::CFG_CEIL;
    cfg_data  <= ceil_val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(sdt_pkg::CFG_CEIL, ceil_val);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    logic [15:0] b;
    logic [15:0] c;
    int          pick;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the whole weight store before any tap reads it
    for (int t = 0; t < NTAPS; t++)
      for (int j = 0; j < NOUT; j++)
        send_load(5'(t), 4'(j), rand_weight());

    send_load(5'd0, 4'd0, 16'h7FFF);
    send_load(5'd0, 4'd15, 16'h8000);
    send_load(5'd31, 4'd0, 16'h7FFF);
    send_load(5'd31, 4'd15, 16'h8000);
    send_load(5'd7, 4'd2, 16'h2000);
    send_load(5'd7, 4'd3, 16'hE000);
    // reset config: saturate high and low
    send_act(5'd0, 16'hFFFF);
    send_act(5'd31, 16'hFFFF);
    send_act(5'd31, 16'h0000);
    // repeats and out-of-order taps
    send_act(5'd5, 16'h0001);
    send_act(5'd5, 16'h0002);
    send_act(5'd3, 16'h8000);
    send_act(5'd31, 16'h0001);
    wait_drained();
    set_config(16'h0000, 16'hFFFF);
    // rounding ties: +0.5 lsb rounds up, -0.5 lsb rounds to zero
    send_act(5'd7, 16'h0001);
    send_act(5'd31, 16'h0000);
    send_act(5'd0, 16'hFFFF);
    send_act(5'd31, 16'hFFFF);
    wait_drained();
    set_config(16'h7FFF, 16'h0000);
    send_act(5'd31, 16'($urandom));

    for (int p = 0; p < NPHASES; p++) begin
      wait_drained();
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      b = bias_tbl[p];
      c = ceil_tbl[p];
      if (p == 4 || p == NPHASES - 1) begin
        b = 16'($urandom);
        c = 16'($urandom);
      end
      set_config(b, c);
      if (p == 4) hold_req <= hold_req + 1;
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 65) send_image();
        else if (pick < 85) send_weights();
        else send_noise();
      end
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending_outputs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
rtl/sdt_pkg.sv
rtl/sdt_wmem.sv
rtl/sdt_mac.sv
rtl/sdt_out.sv
rtl/sparse_dnn_tile_mac_relu.sv
bench/sparse_dnn_tile_mac_relu_tb.sv
